>>> design/apsp_pkg.sv
`default_nettype none

package apsp_pkg;

  // field widths
  localparam int OPC_W     = 2;
  localparam int NODE_W    = 6;
  localparam int DIST_W    = 16;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // defaults and reset values
  localparam int MAX_NODES_DEF = 64;
  localparam logic [DIST_W-1:0] INF_RESET   = 16'd1000;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 7'd64;

  // opcodes
  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPC_W-1:0] OP_EDGE  = 2'd1;
  localparam logic [OPC_W-1:0] OP_RUN   = 2'd2;
  localparam logic [OPC_W-1:0] OP_READ  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INFINITY   = 1'd1;

  // result bit positions in m_tdata
  localparam int UNREACH_BIT = DIST_W;
  localparam int DONE_BIT    = DIST_W + 1;

endpackage

`default_nettype wire

>>> design/apsp_ram.sv
`default_nettype none

module apsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/all_pairs_shortest_path.sv
`default_nettype none

// channel   dir  handshake             payload
// s_*       in   s_tvalid / s_tready   tuser: opcode; tdata: node_a, node_b, weight
// m_*       out  m_tvalid / m_tready   tdata: distance, unreachable, op_done
// cfg_*     in   cfg_we                cfg_index, cfg_wdata
//
// one request at a time; s_tready is high only while the sequencer is idle.
// load edge writes the a-b and b-a entries, read fetches the a-b entry, clear refills
// the matrix (zero diagonal, infinity value elsewhere). run reads the i-k, k-j and i-j
// entries in turn over the single read port of the matrix memory and writes i-j and
// j-i when a step shortens an entry; a row with an infinite i-k entry ends after one
// step. after reset a fill pass over all 2**(2*clog2(MAX_NODES)) entries (4096 at 64
// nodes) writes the reset matrix; no request is taken meanwhile, config writes are.
// a result waits in the output register while m_tready is low; the block stalls
// only when a second result is ready before the first is taken.

module all_pairs_shortest_path #(
  parameter int MAX_NODES = apsp_pkg::MAX_NODES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [apsp_pkg::IN_DATA_W-1:0]   s_tdata,   // node_a, node_b, weight
  input  wire logic [apsp_pkg::OPC_W-1:0]       s_tuser,   // opcode
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [apsp_pkg::OUT_DATA_W-1:0]       m_tdata,   // distance, unreachable, op_done
  input  wire logic                             cfg_we,
  input  wire logic [apsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [apsp_pkg::DIST_W-1:0]      cfg_wdata
);

  import apsp_pkg::*;

  localparam int NW    = $clog2(MAX_NODES);
  localparam int AW    = 2 * NW;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(MAX_NODES + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FILL   = 4'd1;
  localparam logic [3:0] S_EDGE1  = 4'd2;
  localparam logic [3:0] S_EDGE2  = 4'd3;
  localparam logic [3:0] S_RD_ADR = 4'd4;
  localparam logic [3:0] S_RD_DAT = 4'd5;
  localparam logic [3:0] S_RX_IK  = 4'd6;
  localparam logic [3:0] S_RX_KJ  = 4'd7;
  localparam logic [3:0] S_RX_IJ  = 4'd8;
  localparam logic [3:0] S_RX_CMP = 4'd9;
  localparam logic [3:0] S_RX_JI  = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]        state;
  logic [CNT_W-1:0]  node_count;
  logic [DIST_W-1:0] infinity_value;

  logic [AW-1:0]     fill_addr;
  logic [DIST_W-1:0] fill_val;
  logic              fill_reply;

  logic [NW-1:0]     node_a;
  logic [NW-1:0]     node_b;
  logic [DIST_W-1:0] weight;

  logic [NW-1:0]     k, i, j, n_last;
  logic [DIST_W-1:0] d_ik, d_kj;
  logic [DIST_W-1:0] res_dist;
  logic              res_unreach;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [DIST_W-1:0] ram_wdata;
  logic [DIST_W-1:0] ram_rdata;

  logic              in_req;
  logic [OPC_W-1:0]  in_op;
  logic [NODE_W-1:0] in_a, in_b;
  logic              in_range;
  logic [CW-1:0]     n_eff;
  logic [DIST_W:0]   sum;
  logic              ik_inf, kj_inf, better;
  logic              last_j, last_i, last_k;
  logic              out_free;

  // request fields
  assign in_req   = s_tvalid && s_tready;
  assign in_op    = s_tuser;
  assign in_a     = s_tdata[NODE_W-1:0];
  assign in_b     = s_tdata[2*NODE_W-1:NODE_W];
  assign in_range = (32'(in_a) < MAX_NODES) && (32'(in_b) < MAX_NODES);
  assign n_eff    = (32'(node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count);

  // shared adder and compare of the relaxation
  assign sum    = {1'b0, d_ik} + {1'b0, d_kj};
  assign ik_inf = (d_ik == infinity_value);
  assign kj_inf = (d_kj == infinity_value);
  assign better = (sum < {1'b0, ram_rdata});

  assign last_j   = (j == n_last);
  assign last_i   = (i == n_last);
  assign last_k   = (k == n_last);
  assign out_free = !m_tvalid || m_tready;

  assign s_tready = (state == S_IDLE);

  // memory port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {i, j};
    ram_wdata = sum[DIST_W-1:0];
    ram_raddr = {i, j};
    case (state)
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_addr;
        ram_wdata = (fill_addr[AW-1:NW] == fill_addr[NW-1:0]) ? '0 : fill_val;
      end
      S_EDGE1: begin
        ram_we    = 1'b1;
        ram_waddr = {node_a, node_b};
        ram_wdata = weight;
      end
      S_EDGE2: begin
        ram_we    = 1'b1;
        ram_waddr = {node_b, node_a};
        ram_wdata = weight;
      end
      S_RD_ADR: ram_raddr = {node_a, node_b};
      S_RX_IK:  ram_raddr = {i, k};
      S_RX_KJ:  ram_raddr = {k, j};
      S_RX_IJ:  ram_raddr = {i, j};
      S_RX_CMP: begin
        ram_we    = !ik_inf && !kj_inf && better;
        ram_waddr = {i, j};
      end
      S_RX_JI: begin
        ram_we    = 1'b1;
        ram_waddr = {j, i};
      end
      default: ram_we = 1'b0;
    endcase
  end

  apsp_ram #(
    .WIDTH (DIST_W),
    .DEPTH (DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count     <= COUNT_RESET;
      infinity_value <= INF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NODE_COUNT: node_count     <= cfg_wdata[CNT_W-1:0];
        REG_INFINITY:   infinity_value <= cfg_wdata;
        default:        node_count     <= node_count;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      fill_addr  <= '0;
      fill_val   <= INF_RESET;
      fill_reply <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_req) begin
            node_a      <= NW'(in_a);
            node_b      <= NW'(in_b);
            weight      <= s_tdata[2*NODE_W+DIST_W-1:2*NODE_W];
            res_dist    <= '0;
            res_unreach <= 1'b0;
            k           <= '0;
            i           <= '0;
            j           <= '0;
            n_last      <= NW'(n_eff - CW'(1));
            case (in_op)
              OP_CLEAR: begin
                fill_addr  <= '0;
                fill_val   <= infinity_value;
                fill_reply <= 1'b1;
                state      <= S_FILL;
              end
              OP_EDGE: state <= in_range ? S_EDGE1 : S_DONE;
              OP_RUN:  state <= (n_eff == '0) ? S_DONE : S_RX_IK;
              OP_READ: state <= in_range ? S_RD_ADR : S_DONE;
              default: state <= S_DONE;
            endcase
          end
        end
        S_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          if (fill_addr == '1) begin
            state <= fill_reply ? S_DONE : S_IDLE;
          end
        end
        S_EDGE1: state <= S_EDGE2;
        S_EDGE2: state <= S_DONE;
        S_RD_ADR: state <= S_RD_DAT;
        S_RD_DAT: begin
          res_dist    <= ram_rdata;
          res_unreach <= (ram_rdata == infinity_value);
          state       <= S_DONE;
        end
        S_RX_IK: state <= S_RX_KJ;
        S_RX_KJ: begin
          d_ik  <= ram_rdata;
          state <= S_RX_IJ;
        end
        S_RX_IJ: begin
          d_kj  <= ram_rdata;
          state <= S_RX_CMP;
        end
        S_RX_CMP, S_RX_JI: begin
          if (state == S_RX_CMP && !ik_inf && !kj_inf && better) begin
            // mirror write next
            state <= S_RX_JI;
          end else if (!ik_inf && !last_j) begin
            j     <= j + NW'(1);
            state <= S_RX_IK;
          end else begin
            // row done, or the i-k entry is infinite
            j <= '0;
            if (!last_i) begin
              i     <= i + NW'(1);
              state <= S_RX_IK;
            end else begin
              i <= '0;
              if (last_k) begin
                state <= S_DONE;
              end else begin
                k     <= k + NW'(1);
                state <= S_RX_IK;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata  <= {(OUT_DATA_W - DIST_W - 2)'(0), 1'b1, res_unreach, res_dist};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/apsp_checker.sv
`default_nettype none

module apsp_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [apsp_pkg::OUT_DATA_W-1:0]  m_tdata
);

  import apsp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // every result reports completion
  a_done_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[DONE_BIT])
    else $error("result without op_done");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // a fresh result comes out of a busy sequencer
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while idle");

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
